// ===== rtl/core/mmbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmbp_pkg
// Shared codes and counter helpers for the multi-mode branch predictor.
// ----------------------------------------------------------------------------
package mmbp_pkg;

  typedef enum logic [1:0] {
    MODE_STATIC = 2'd0,
    MODE_GSHARE = 2'd1,
    MODE_TOUR   = 2'd2,
    MODE_CUSTOM = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_GHIST = 2'd1,
    REG_LHIST = 2'd2,
    REG_PCIDX = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ1 = 5'b00100,
    ST_READ2 = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  localparam logic [1:0] CTR_WNT = 2'd1;
  localparam logic [1:0] CTR_WT  = 2'd2;

  // 2-bit saturating update
  function automatic logic [1:0] bump(input logic [1:0] c, input logic up);
    logic [1:0] r;
    r = c;
    if (up) begin
      if (c != 2'd3) r = c + 2'd1;
    end else begin
      if (c != 2'd0) r = c - 2'd1;
    end
    return r;
  endfunction

  function automatic logic [3:0] clamp_bits(input logic [3:0] v, input logic [3:0] maxv);
    logic [3:0] r;
    r = v;
    if (v == 4'd0) r = 4'd1;
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

// ===== rtl/core/multi_mode_branch_predictor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_mode_branch_predictor
// Static, gshare, tournament and custom per-pc table branch predictor.
// ----------------------------------------------------------------------------
// Each request carries a branch pc and its resolved outcome; one result comes
// back with the prediction made from the state before the branch and a
// mispredict flag, after which the selected scheme trains. All counters live
// in single-port synchronous RAMs with registered reads. After acceptance a
// request passes ST_READ1, ST_READ2 and ST_OUT, and no new request is taken
// until its result has been loaded: the tournament local counter address
// depends on the local history read, so two dependent RAM reads are done
// before the write back. The local history read is issued at acceptance, the
// local counter read in ST_READ2. Training and the result load wait while the
// result register holds an undrained result; the input stays closed until
// then. After reset a clearing pass sweeps the largest table (at the defaults
// the custom table, CUSTOM_TABLES << CUSTOM_HIST_BITS = 524288 entries) while
// no request is accepted; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module multi_mode_branch_predictor
  import mmbp_pkg::*;
#(
  parameter int GHIST_MAX        = 13,
  parameter int LHIST_MAX        = 11,
  parameter int PC_INDEX_MAX     = 10,
  parameter int CUSTOM_TABLES    = 512,
  parameter int CUSTOM_HIST_BITS = 10,
  parameter int CUSTOM_PC_BITS   = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_branch_pc,
  input  logic        in_taken,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_predicted_taken,
  output logic        out_mispredicted,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int HIST_W = (GHIST_MAX > CUSTOM_HIST_BITS) ? GHIST_MAX : CUSTOM_HIST_BITS;
  localparam int GSIZE  = 1 << GHIST_MAX;
  localparam int LSIZE  = 1 << LHIST_MAX;
  localparam int PSIZE  = 1 << PC_INDEX_MAX;
  localparam int TAB_W  = (CUSTOM_TABLES > 1) ? $clog2(CUSTOM_TABLES) : 1;
  localparam int CSIZE  = CUSTOM_TABLES << CUSTOM_HIST_BITS;
  localparam int CA_W   = $clog2(CSIZE) + 1;
  // sweep length covers every table
  localparam int M1     = (CSIZE > GSIZE) ? CSIZE : GSIZE;
  localparam int M2     = (LSIZE > PSIZE) ? LSIZE : PSIZE;
  localparam int SWEEP  = (M1 > M2) ? M1 : M2;
  localparam int SW_W   = $clog2(SWEEP) + 1;
  localparam int MAXB   = (GHIST_MAX > PC_INDEX_MAX) ? GHIST_MAX : PC_INDEX_MAX;
  localparam int CPC_W  = (CUSTOM_PC_BITS > 32) ? 32 : CUSTOM_PC_BITS;

  // memories
  logic [1:0]           gsh_mem  [GSIZE];
  logic [1:0]           tgl_mem  [GSIZE];
  logic [1:0]           chs_mem  [GSIZE];
  logic [LHIST_MAX-1:0] lhs_mem  [PSIZE];
  logic [1:0]           lct_mem  [LSIZE];
  logic [1:0]           cus_mem  [CSIZE];

  state_t state_r, state_nxt;
  logic [SW_W-1:0] clr_r;

  logic [1:0] mode_r;
  logic [3:0] gbits_r, lbits_r, pbits_r;
  logic [HIST_W-1:0] ghist_r;

  logic        t_r;
  logic [GHIST_MAX-1:0] gi_r;
  logic [PC_INDEX_MAX-1:0] pi_r;
  logic [LHIST_MAX-1:0] li_r;
  logic [CA_W-2:0] ci_r;

  logic [1:0] gsh_q, tgl_q, chs_q, lct_q, cus_q;
  logic [LHIST_MAX-1:0] lhs_q;

  logic res_v_r, res_p_r, res_m_r;

  // masks from clamped widths
  logic [3:0] gb, lb, pb;
  logic [GHIST_MAX-1:0] gmask;
  logic [LHIST_MAX-1:0] lmask;
  logic [PC_INDEX_MAX-1:0] pmask;
  assign gb = clamp_bits(gbits_r, 4'(GHIST_MAX > 15 ? 15 : GHIST_MAX));
  assign lb = clamp_bits(lbits_r, 4'(LHIST_MAX > 15 ? 15 : LHIST_MAX));
  assign pb = clamp_bits(pbits_r, 4'(PC_INDEX_MAX > 15 ? 15 : PC_INDEX_MAX));
  assign gmask = GHIST_MAX'(({MAXB{1'b1}} << gb) ^ {MAXB{1'b1}});
  assign lmask = LHIST_MAX'(({LHIST_MAX{1'b1}} << lb) ^ {LHIST_MAX{1'b1}});
  assign pmask = PC_INDEX_MAX'(({MAXB{1'b1}} << pb) ^ {MAXB{1'b1}});

  logic [HIST_W+32-1:0] gx;
  assign gx = {{32{1'b0}}, ghist_r} ^ {{HIST_W{1'b0}}, in_branch_pc};

  logic [CPC_W-1:0] cpc;
  logic [TAB_W-1:0] tab;
  assign cpc = in_branch_pc[CPC_W-1:0];
  assign tab = TAB_W'(32'(cpc) % CUSTOM_TABLES);

  logic accept, out_take;
  assign out_take = res_v_r && out_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = res_v_r;
  assign out_predicted_taken = res_p_r;
  assign out_mispredicted = res_m_r;

  // local history address: straight from the request at acceptance
  logic [PC_INDEX_MAX-1:0] lhs_ra;
  assign lhs_ra = accept ? (in_branch_pc[PC_INDEX_MAX-1:0] & pmask) : pi_r;

  // prediction / training
  logic gp, lp, pred;
  always_comb begin
    gp = tgl_q[1];
    lp = lct_q[1];
    unique case (mode_r)
      MODE_GSHARE: pred = gsh_q[1];
      MODE_TOUR:   pred = chs_q[1] ? gp : lp;
      MODE_CUSTOM: pred = cus_q[1];
      default:     pred = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == SW_W'(SWEEP - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = ST_READ1;
      ST_READ1: state_nxt = ST_READ2;
      ST_READ2: state_nxt = ST_OUT;
      ST_OUT:   if (!res_v_r || out_take) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      mode_r  <= MODE_GSHARE;
      gbits_r <= 4'd13;
      lbits_r <= 4'd11;
      pbits_r <= 4'd10;
      ghist_r <= '0;
      res_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_MODE:  mode_r  <= cfg_data[1:0];
          REG_GHIST: gbits_r <= cfg_data;
          REG_LHIST: lbits_r <= cfg_data;
          REG_PCIDX: pbits_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_OUT && (!res_v_r || out_take)) begin
        res_v_r <= 1'b1;
        if (mode_r != MODE_STATIC) ghist_r <= {ghist_r[HIST_W-2:0], t_r};
      end else if (out_take) begin
        res_v_r <= 1'b0;
      end
    end
  end

  // capture request and indices
  always_ff @(posedge clk) begin
    if (accept) begin
      t_r  <= in_taken;
      pi_r <= in_branch_pc[PC_INDEX_MAX-1:0] & pmask;
      ci_r <= (CA_W-1)'({tab, ghist_r[CUSTOM_HIST_BITS-1:0]});
      if (mode_r == MODE_GSHARE) gi_r <= gx[GHIST_MAX-1:0] & gmask;
      else gi_r <= ghist_r[GHIST_MAX-1:0] & gmask;
    end
    if (state_r == ST_READ1) li_r <= lhs_q & lmask;
    if (state_r == ST_OUT && (!res_v_r || out_take)) begin
      res_p_r <= pred;
      res_m_r <= pred ^ t_r;
    end
  end

  // table ports: local history read at acceptance, other reads in READ1/READ2,
  // write back in OUT, sweep in CLEAR
  logic wr;
  assign wr = (state_r == ST_OUT) && (!res_v_r || out_take);

  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      if (clr_r < SW_W'(GSIZE)) begin
        gsh_mem[clr_r[GHIST_MAX-1:0]] <= CTR_WNT;
        tgl_mem[clr_r[GHIST_MAX-1:0]] <= CTR_WNT;
        chs_mem[clr_r[GHIST_MAX-1:0]] <= CTR_WT;
      end
    end else if (wr && mode_r == MODE_GSHARE) begin
      gsh_mem[gi_r] <= bump(gsh_q, t_r);
    end else if (wr && mode_r == MODE_TOUR) begin
      tgl_mem[gi_r] <= bump(tgl_q, t_r);
      if (gp != lp) chs_mem[gi_r] <= bump(chs_q, gp == t_r);
    end
    gsh_q <= gsh_mem[gi_r];
    tgl_q <= tgl_mem[gi_r];
    chs_q <= chs_mem[gi_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      if (clr_r < SW_W'(PSIZE)) lhs_mem[clr_r[PC_INDEX_MAX-1:0]] <= '0;
    end else if (wr && mode_r == MODE_TOUR) begin
      lhs_mem[pi_r] <= {lhs_q[LHIST_MAX-2:0], t_r};
    end
    lhs_q <= lhs_mem[lhs_ra];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      if (clr_r < SW_W'(LSIZE)) lct_mem[clr_r[LHIST_MAX-1:0]] <= CTR_WNT;
    end else if (wr && mode_r == MODE_TOUR) begin
      lct_mem[li_r] <= bump(lct_q, t_r);
    end
    lct_q <= lct_mem[li_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      if (clr_r < SW_W'(CSIZE)) cus_mem[clr_r[CA_W-2:0]] <= CTR_WNT;
    end else if (wr && mode_r == MODE_CUSTOM) begin
      cus_mem[ci_r] <= bump(cus_q, t_r);
    end
    cus_q <= cus_mem[ci_r];
  end

`ifndef SYNTHESIS
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_ready) else $error("accept during clear");
  a_read_seq: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_READ1 ##1 state_r == ST_READ2) else $error("read sequence");
  a_mis: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_v_r) |-> res_m_r == (res_p_r ^ t_r)) else $error("mispredict flag");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_v_r && !out_ready |=> res_v_r && $stable(res_p_r)) else $error("result lost");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multi-mode branch predictor.
// ----------------------------------------------------------------------------
// A local model of the predictor tables tracks every accepted branch request
// and queues the expected prediction and mispredict flag. A monitor compares
// each result against the oldest queued prediction. Tests walk through every
// mode and several table-width settings, including the extremes, and run
// random branch streams under three handshake idling profiles. One stretch
// holds off the result side long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module testbench;
  import mmbp_pkg::*;

  localparam int HIST_W   = 13;
  localparam int GSZ      = 8192;
  localparam int LSZ      = 2048;
  localparam int PSZ      = 1024;
  localparam int CSZ      = 512 * 1024;
  // Clearing pass plus ~900 requests at worst-case stalls, with margin.
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic pred;
    logic miss;
  } branch_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_branch_pc;
  logic        in_taken;
  logic        out_valid;
  logic        out_ready;
  logic        out_predicted_taken;
  logic        out_mispredicted;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [3:0]  cfg_data;

  multi_mode_branch_predictor dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_branch_pc        (in_branch_pc),
    .in_taken            (in_taken),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_predicted_taken (out_predicted_taken),
    .out_mispredicted    (out_mispredicted),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // Shadow predictor state
  mode_t       m_mode;
  logic [3:0]  m_gbits, m_lbits, m_pbits;
  logic [HIST_W-1:0] m_ghist;
  logic [1:0]  m_gshare [GSZ];
  logic [1:0]  m_tglob  [GSZ];
  logic [1:0]  m_choose [GSZ];
  logic [10:0] m_lhist  [PSZ];
  logic [1:0]  m_lctr   [LSZ];
  logic [1:0]  m_cctr   [CSZ];

  branch_result_t expected_q[$];

  int  errors;
  int  cycles;
  int  send_idle_pct;   // chance in percent the sender skips a cycle
  int  recv_idle_pct;   // chance in percent the receiver stalls a cycle
  int  hold_cycles;     // long receiver hold-off, counted in its own process
  bit  hold_req;

  // Clock and run limit
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [1:0] sat_step(logic [1:0] c, logic up);
    if (up) return (c == 2'd3) ? c : c + 2'd1;
    return (c == 2'd0) ? c : c - 2'd1;
  endfunction

  function automatic logic [31:0] width_mask(logic [3:0] v, int maxv);
    int b;
    b = (v == 0) ? 1 : ((v > maxv) ? maxv : v);
    return (32'd1 << b) - 32'd1;
  endfunction

  task automatic reset_shadow();
    m_mode  = MODE_GSHARE;
    m_gbits = 4'd13;
    m_lbits = 4'd11;
    m_pbits = 4'd10;
    m_ghist = '0;
    foreach (m_gshare[i]) begin
      m_gshare[i] = CTR_WNT;
      m_tglob[i]  = CTR_WNT;
      m_choose[i] = CTR_WT;
    end
    foreach (m_lhist[i]) m_lhist[i] = '0;
    foreach (m_lctr[i]) m_lctr[i] = CTR_WNT;
    foreach (m_cctr[i]) m_cctr[i] = CTR_WNT;
  endtask

  // Predict one branch from the current state, then train.
  function automatic branch_result_t predict_branch(logic [31:0] pc, logic t);
    branch_result_t r;
    logic p;
    logic gp, lp;
    int gi, pi, li, ci;
    p = 1'b1;
    case (m_mode)
      MODE_GSHARE: begin
        gi = (32'(m_ghist) ^ pc) & width_mask(m_gbits, 13);
        p = m_gshare[gi][1];
        m_gshare[gi] = sat_step(m_gshare[gi], t);
        m_ghist = {m_ghist[HIST_W-2:0], t};
      end
      MODE_TOUR: begin
        gi = 32'(m_ghist) & width_mask(m_gbits, 13);
        pi = pc & width_mask(m_pbits, 10);
        li = 32'(m_lhist[pi]) & width_mask(m_lbits, 11);
        gp = m_tglob[gi][1];
        lp = m_lctr[li][1];
        p = m_choose[gi][1] ? gp : lp;
        if (gp != lp) m_choose[gi] = sat_step(m_choose[gi], gp == t);
        m_tglob[gi] = sat_step(m_tglob[gi], t);
        m_lctr[li] = sat_step(m_lctr[li], t);
        m_lhist[pi] = {m_lhist[pi][9:0], t};
        m_ghist = {m_ghist[HIST_W-2:0], t};
      end
      MODE_CUSTOM: begin
        ci = {pc[8:0], m_ghist[9:0]};
        p = m_cctr[ci][1];
        m_cctr[ci] = sat_step(m_cctr[ci], t);
        m_ghist = {m_ghist[HIST_W-2:0], t};
      end
      default: ;  // static taken: nothing trains
    endcase
    r.pred = p;
    r.miss = p ^ t;
    return r;
  endfunction

  // Send one branch request; the expectation is queued at acceptance.
  // Valid stays up after acceptance so back to back requests need no gap;
  // whoever stops sending drops it.
  task automatic send_branch(logic [31:0] pc, logic t);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_branch_pc <= pc;
    in_taken     <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(predict_branch(pc, t));
  endtask

  task automatic write_reg(reg_idx_t idx, logic [3:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MODE:  m_mode  = mode_t'(value[1:0]);
      REG_GHIST: m_gbits = value;
      REG_LHIST: m_lbits = value;
      default:   m_pbits = value;
    endcase
  endtask

  // Wait for every outstanding result before reconfiguring.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(mode_t md, logic [3:0] g, logic [3:0] l, logic [3:0] p);
    drain();
    write_reg(REG_MODE, 4'(md));
    write_reg(REG_GHIST, g);
    write_reg(REG_LHIST, l);
    write_reg(REG_PCIDX, p);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req && hold_cycles > 0) begin
      out_ready   <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    branch_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result pred=%0b miss=%0b", $time,
                 out_predicted_taken, out_mispredicted);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_predicted_taken !== e.pred) begin
          $display("%0t: predicted_taken exp=%0b got=%0b", $time, e.pred,
                   out_predicted_taken);
          errors++;
        end
        if (out_mispredicted !== e.miss) begin
          $display("%0t: mispredicted exp=%0b got=%0b", $time, e.miss,
                   out_mispredicted);
          errors++;
        end
      end
    end
  end

  // Directed: field extremes in every mode, static mode, width clamping.
  task automatic test_directed();
    send_branch(32'h0000_0000, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'h8000_0001, 1'b0);
    configure(MODE_STATIC, 4'd13, 4'd11, 4'd10);
    send_branch(32'h1234_5678, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b1);
    configure(MODE_TOUR, 4'd0, 4'd0, 4'd0);       // zero widths act as one
    repeat (4) send_branch(32'h0000_0003, 1'b1);
    send_branch(32'h0000_0002, 1'b0);
    send_branch(32'h0000_0003, 1'b0);
    configure(MODE_TOUR, 4'd15, 4'd15, 4'd15);    // above max act as max
    repeat (3) send_branch(32'hAAAA_5555, 1'b1);
    send_branch(32'h5555_AAAA, 1'b0);
    configure(MODE_CUSTOM, 4'd13, 4'd11, 4'd10);
    send_branch(32'h0000_01FF, 1'b1);
    send_branch(32'hFFFF_FE00, 1'b0);
    send_branch(32'h0000_01FF, 1'b1);
    send_branch(32'h0000_01FF, 1'b1);
  endtask

  // Random branch streams: a small set of loop-like pcs with biased outcomes
  // so counters actually saturate, mixed with fully random noise.
  task automatic random_stream(int count);
    logic [31:0] pcs[8];
    int k;
    foreach (pcs[i]) pcs[i] = $urandom();
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(7);
      if ($urandom_range(9) < 8)
        send_branch(pcs[k], ($urandom_range(9) < (k + 1)) ? 1'b1 : 1'b0);
      else
        send_branch($urandom(), 1'($urandom()));
    end
  endtask

  task automatic test_random_modes();
    configure(MODE_GSHARE, 4'd13, 4'd11, 4'd10);
    random_stream(120);
    configure(MODE_TOUR, 4'd1, 4'd1, 4'd1);
    random_stream(60);
    configure(MODE_TOUR, 4'($urandom_range(2, 12)), 4'($urandom_range(2, 10)),
              4'($urandom_range(2, 9)));
    random_stream(160);
    configure(MODE_GSHARE, 4'd1, 4'd11, 4'd10);
    random_stream(60);
    configure(MODE_CUSTOM, 4'd13, 4'd11, 4'd10);
    random_stream(120);
    configure(MODE_STATIC, 4'd7, 4'd5, 4'd3);
    random_stream(30);
    configure(MODE_TOUR, 4'd13, 4'd11, 4'd10);
    random_stream(150);
  endtask

  // Long receiver hold-off while the sender keeps offering requests.
  task automatic test_backpressure();
    configure(MODE_GSHARE, 4'd9, 4'd11, 4'd10);
    hold_cycles = 60;
    hold_req    = 1'b1;
    random_stream(40);
    hold_req = 1'b0;
  endtask

  initial begin
    errors        = 0;
    cycles        = 0;
    hold_req      = 1'b0;
    hold_cycles   = 0;
    send_idle_pct = 21;
    recv_idle_pct = 85;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_branch_pc  = '0;
    in_taken      = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_MODE;
    cfg_data      = '0;
    reset_shadow();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    send_idle_pct = 21;
    recv_idle_pct = 85;
    random_stream(40);
    send_idle_pct = 85;
    recv_idle_pct = 21;
    test_random_modes();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    configure(MODE_CUSTOM, 4'd13, 4'd11, 4'd10);
    random_stream(100);

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
